// ===== rtl/control_frame_builder_macros.svh =====
// Assertion helpers for the control frame builder.
// Both sample on clk and are switched off while arst_n is low.
`ifndef CONTROL_FRAME_BUILDER_MACROS_SVH
`define CONTROL_FRAME_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cfb_pkg.sv =====
package cfb_pkg;

	localparam int FRAME_LEN = 17;
	localparam int SUM_LEN = 13;
	localparam int IDX_W = $clog2(FRAME_LEN);
	// Thirteen bytes of at most 255 each never exceed twelve bits.
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_HEADER_FIRST = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_REPEAT_COUNT = 2'd2;

	localparam logic [CNT_W-1:0] REPEAT_RESET = 4'd3;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	// Byte positions within the frame.
	localparam logic [IDX_W-1:0] POS_HEADER_FIRST = 5'd0;
	localparam logic [IDX_W-1:0] POS_HEADER_SECOND = 5'd1;
	localparam logic [IDX_W-1:0] POS_YAW_HI = 5'd2;
	localparam logic [IDX_W-1:0] POS_YAW_LO = 5'd3;
	localparam logic [IDX_W-1:0] POS_THROTTLE_HI = 5'd4;
	localparam logic [IDX_W-1:0] POS_THROTTLE_LO = 5'd5;
	localparam logic [IDX_W-1:0] POS_PITCH_HI = 5'd6;
	localparam logic [IDX_W-1:0] POS_PITCH_LO = 5'd7;
	localparam logic [IDX_W-1:0] POS_ROLL_HI = 5'd8;
	localparam logic [IDX_W-1:0] POS_ROLL_LO = 5'd9;
	localparam logic [IDX_W-1:0] POS_SHUTDOWN = 5'd10;
	localparam logic [IDX_W-1:0] POS_HOLD_HEIGHT = 5'd11;
	localparam logic [IDX_W-1:0] POS_UNLOCK = 5'd12;
	localparam logic [IDX_W-1:0] POS_SUM_B3 = 5'd13;
	localparam logic [IDX_W-1:0] POS_SUM_B2 = 5'd14;
	localparam logic [IDX_W-1:0] POS_SUM_B1 = 5'd15;
	localparam logic [IDX_W-1:0] POS_SUM_B0 = 5'd16;

	typedef struct packed {
		logic        kind;
		logic [15:0] yaw_value;
		logic [15:0] throttle_value;
		logic [15:0] pitch_value;
		logic [15:0] roll_value;
		logic        shutdown_request;
		logic        hold_height_request;
		logic        unlock_request;
		logic        sent_ok;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} out_item_t;

	typedef struct packed {
		logic [15:0] yaw_value;
		logic [15:0] throttle_value;
		logic [15:0] pitch_value;
		logic [15:0] roll_value;
		logic        shutdown_flag;
		logic        hold_height_flag;
		logic        unlock_flag;
	} job_t;

	typedef struct packed {
		logic [CNT_W-1:0] shutdown_left;
		logic [CNT_W-1:0] hold_height_left;
		logic [CNT_W-1:0] unlock_left;
	} front_stat_t;

	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] idx;
		logic [7:0]       frame_byte;
	} back_stat_t;

endpackage

// ===== rtl/cfb_front.sv =====
module cfb_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  cfb_pkg::in_item_t         in_item,
	input  logic [cfb_pkg::CNT_W-1:0] repeat_count,
	input  logic                      q_full,
	output logic                      q_push,
	output cfb_pkg::job_t             q_job,
	output cfb_pkg::front_stat_t      stat
);

	logic accept;
	logic is_frame;
	logic outcome_ok;
	logic [cfb_pkg::CNT_W-1:0] shutdown_left_q;
	logic [cfb_pkg::CNT_W-1:0] hold_height_left_q;
	logic [cfb_pkg::CNT_W-1:0] unlock_left_q;
	logic [cfb_pkg::CNT_W-1:0] shutdown_d;
	logic [cfb_pkg::CNT_W-1:0] hold_height_d;
	logic [cfb_pkg::CNT_W-1:0] unlock_d;

	function automatic logic [cfb_pkg::CNT_W-1:0] next_count(
		input logic                      req,
		input logic [cfb_pkg::CNT_W-1:0] cur,
		input logic [cfb_pkg::CNT_W-1:0] reload,
		input logic                      load_en,
		input logic                      dec_en
	);
		logic [cfb_pkg::CNT_W-1:0] res;
		res = cur;
		if (load_en && req) begin
			res = reload;
		end else if (dec_en && cur != '0) begin
			res = cur - 1'b1;
		end
		return res;
	endfunction

	always_comb begin
		accept = push && !q_full;
		is_frame = accept && in_item.kind == cfb_pkg::KIND_FRAME;
		outcome_ok = accept && in_item.kind == cfb_pkg::KIND_OUTCOME && in_item.sent_ok;
		shutdown_d = next_count(in_item.shutdown_request, shutdown_left_q, repeat_count,
			is_frame, outcome_ok);
		hold_height_d = next_count(in_item.hold_height_request, hold_height_left_q,
			repeat_count, is_frame, outcome_ok);
		unlock_d = next_count(in_item.unlock_request, unlock_left_q, repeat_count,
			is_frame, outcome_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shutdown_left_q <= '0;
			hold_height_left_q <= '0;
			unlock_left_q <= '0;
		end else begin
			shutdown_left_q <= shutdown_d;
			hold_height_left_q <= hold_height_d;
			unlock_left_q <= unlock_d;
		end
	end

	// Flags reflect the counters after this frame's own requests are applied.
	always_comb begin
		q_push = is_frame;
		q_job.yaw_value = in_item.yaw_value;
		q_job.throttle_value = in_item.throttle_value;
		q_job.pitch_value = in_item.pitch_value;
		q_job.roll_value = in_item.roll_value;
		q_job.shutdown_flag = shutdown_d != '0;
		q_job.hold_height_flag = hold_height_d != '0;
		q_job.unlock_flag = unlock_d != '0;
		stat.shutdown_left = shutdown_left_q;
		stat.hold_height_left = hold_height_left_q;
		stat.unlock_left = unlock_left_q;
	end

endmodule

// ===== rtl/cfb_queue.sv =====
module cfb_queue #(
	parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfb_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output cfb_pkg::job_t dout,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfb_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cfb_back.sv =====
module cfb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  cfb_pkg::job_t        q_job,
	output logic                 q_pop,
	input  logic [7:0]           header_first,
	input  logic [7:0]           header_second,
	input  logic                 pop,
	output logic                 empty,
	output cfb_pkg::out_item_t   out_item,
	output cfb_pkg::back_stat_t  stat
);

	cfb_pkg::job_t job_q;
	logic busy_q;
	logic [cfb_pkg::IDX_W-1:0] idx_q;
	logic [cfb_pkg::SUM_W-1:0] sum_q;
	cfb_pkg::out_item_t out_q;
	logic out_valid_q;
	logic advance;
	logic emit;
	logic last;
	logic [7:0] cur_byte;

	always_comb begin
		case (idx_q)
			cfb_pkg::POS_HEADER_FIRST:  cur_byte = header_first;
			cfb_pkg::POS_HEADER_SECOND: cur_byte = header_second;
			cfb_pkg::POS_YAW_HI:        cur_byte = job_q.yaw_value[15:8];
			cfb_pkg::POS_YAW_LO:        cur_byte = job_q.yaw_value[7:0];
			cfb_pkg::POS_THROTTLE_HI:   cur_byte = job_q.throttle_value[15:8];
			cfb_pkg::POS_THROTTLE_LO:   cur_byte = job_q.throttle_value[7:0];
			cfb_pkg::POS_PITCH_HI:      cur_byte = job_q.pitch_value[15:8];
			cfb_pkg::POS_PITCH_LO:      cur_byte = job_q.pitch_value[7:0];
			cfb_pkg::POS_ROLL_HI:       cur_byte = job_q.roll_value[15:8];
			cfb_pkg::POS_ROLL_LO:       cur_byte = job_q.roll_value[7:0];
			cfb_pkg::POS_SHUTDOWN:      cur_byte = {7'd0, job_q.shutdown_flag};
			cfb_pkg::POS_HOLD_HEIGHT:   cur_byte = {7'd0, job_q.hold_height_flag};
			cfb_pkg::POS_UNLOCK:        cur_byte = {7'd0, job_q.unlock_flag};
			cfb_pkg::POS_SUM_B1:        cur_byte = 8'(sum_q >> 8);
			cfb_pkg::POS_SUM_B0:        cur_byte = sum_q[7:0];
			// The two top checksum bytes are always zero.
			default:                    cur_byte = 8'd0;
		endcase
	end

	always_comb begin
		advance = !out_valid_q || pop;
		emit = busy_q && advance;
		last = idx_q == cfb_pkg::POS_SUM_B0;
		q_pop = !q_empty && (!busy_q || (emit && last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (emit) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			sum_q <= '0;
		end else if (emit && idx_q < cfb_pkg::IDX_W'(cfb_pkg::SUM_LEN)) begin
			sum_q <= sum_q + cfb_pkg::SUM_W'(cur_byte);
		end
		if (emit) begin
			out_q.frame_byte <= cur_byte;
			out_q.last_byte <= last;
		end
	end

	assign empty = !out_valid_q;
	assign out_item = out_q;
	assign stat.load = emit;
	assign stat.idx = idx_q;
	assign stat.frame_byte = cur_byte;

endmodule

// ===== rtl/control_frame_builder.sv =====
// A frame transaction is accepted into the job queue, loaded into the byte sequencer
// once the sequencer is idle, and its bytes then pass through the output register.
// A frame is seventeen bytes, sent one byte per cycle while the consumer keeps popping.
// An outcome transaction produces no bytes.
// Reset is asynchronous, active low: command counters clear, headers go to zero,
// the repeat count goes to three, and the queue and output register empty.
`include "control_frame_builder_macros.svh"

module control_frame_builder #(
	parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input queue side.
	input  logic                        push,
	output logic                        full,
	input  cfb_pkg::in_item_t           in_item,
	// Result queue side.
	output logic                        empty,
	input  logic                        pop,
	output cfb_pkg::out_item_t          out_item,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfb_pkg::PADDR_W-1:0] paddr,
	input  logic [cfb_pkg::PDATA_W-1:0] pwdata,
	output logic [cfb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	// Configuration registers. Change them only while the block is idle; it does
	// not enforce it. The back end reads header bytes straight from here as it emits.
	logic [7:0] header_first_q;
	logic [7:0] header_second_q;
	logic [cfb_pkg::CNT_W-1:0] repeat_count_q;
	logic cfg_write;
	logic [1:0] reg_idx;

	// Queue between the classifier and the byte sequencer.
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cfb_pkg::job_t q_job_in;
	cfb_pkg::job_t q_job_out;

	cfb_pkg::front_stat_t front_stat;
	cfb_pkg::back_stat_t back_stat;

	// Conditions watched by the checks at the end.
	logic sum_top_byte;
	logic ack_shutdown;
	logic [cfb_pkg::CNT_W-1:0] shutdown_cnt;
	logic [cfb_pkg::CNT_W-1:0] shutdown_less;

	assign pready = 1'b1;
	assign reg_idx = paddr[cfb_pkg::PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q <= '0;
			header_second_q <= '0;
			repeat_count_q <= cfb_pkg::REPEAT_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				cfb_pkg::REG_HEADER_FIRST:  header_first_q <= pwdata[7:0];
				cfb_pkg::REG_HEADER_SECOND: header_second_q <= pwdata[7:0];
				cfb_pkg::REG_REPEAT_COUNT:  repeat_count_q <= pwdata[cfb_pkg::CNT_W-1:0];
				// Writes to unmapped addresses are dropped.
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cfb_pkg::REG_HEADER_FIRST:  prdata = {24'd0, header_first_q};
			cfb_pkg::REG_HEADER_SECOND: prdata = {24'd0, header_second_q};
			cfb_pkg::REG_REPEAT_COUNT:  prdata = {28'd0, repeat_count_q};
			default:                    prdata = '0;
		endcase
	end

	// The front end owns the command counters. Every transaction passes
	// through it in order, so it can fix each frame's command flags at
	// acceptance and hand the back end a self-contained job. Outcome
	// transactions stop here. It stalls only when the job queue is full.
	assign full = q_full;

	cfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.in_item      (in_item),
		.repeat_count (repeat_count_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (q_job_in),
		.stat         (front_stat)
	);

	cfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_job_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_job_out),
		.empty  (q_empty)
	);

	// The back end walks one job byte by byte into an output register,
	// summing the first thirteen bytes on the way for the checksum. It takes
	// the next job in the same cycle that it emits the last byte, so frames
	// follow each other with no gap while the consumer keeps popping.
	cfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (q_job_out),
		.q_pop         (q_pop),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.pop           (pop),
		.empty         (empty),
		.out_item      (out_item),
		.stat          (back_stat)
	);

	assign sum_top_byte = back_stat.load
		&& (back_stat.idx inside {cfb_pkg::POS_SUM_B3, cfb_pkg::POS_SUM_B2});
	assign shutdown_cnt = front_stat.shutdown_left;
	assign shutdown_less = front_stat.shutdown_left - 1'b1;
	assign ack_shutdown = push && !full && in_item.kind == cfb_pkg::KIND_OUTCOME
		&& in_item.sent_ok && front_stat.shutdown_left != '0;

	// The front end never writes a job into a full queue.
	`CFB_ASSERT_NOW(a_no_queue_overflow, q_push, !q_full, "job pushed into a full queue")

	// The checksum never reaches its two top bytes.
	`CFB_ASSERT_NOW(a_sum_high_zero, sum_top_byte, back_stat.frame_byte == 8'd0, "checksum high byte")

	// An acknowledged outcome counts a live shutdown command down by one.
	`CFB_ASSERT_NEXT(a_shutdown_dec, ack_shutdown, shutdown_cnt == $past(shutdown_less), "no decrement")

endmodule
